// ===== src/rdsd_pkg.sv =====
package rdsd_pkg;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int AMP_W = 24;
	localparam int TIME_W = 32;
	localparam int COS_W = 16;
	localparam int DIV_Q_W = 24;
	localparam int DIV_NUM_W = AMP_W + TIME_W;
	localparam int DIV_STAGES = DIV_Q_W;
	localparam int OUT_W = 32;

	typedef enum logic [2:0] {
		REG_DC_LEVEL  = 3'd0,
		REG_AC_AMP    = 3'd1,
		REG_PH_STEP   = 3'd2,
		REG_PH_OFFSET = 3'd3,
		REG_DELAY     = 3'd4,
		REG_RISE      = 3'd5,
		REG_ENV_END   = 3'd6,
		REG_NONE      = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [AMP_W-1:0] dc_level;
		logic signed [AMP_W-1:0] ac_amplitude;
		logic [31:0]             phase_step;
		logic [15:0]             phase_offset;
		logic [TIME_W-1:0]       delay_ticks;
		logic [TIME_W-1:0]       rise_ticks;
		logic [TIME_W-1:0]       envelope_end_ticks;
	} cfg_t;

	// per-item control carried alongside the divider
	typedef struct packed {
		logic                    ramp_on;
		logic                    env_on;
		logic                    dc_neg;
		logic                    env_neg;
		logic signed [COS_W-1:0] cos_val;
	} side_t;

	typedef struct packed {
		logic [TIME_W-1:0]  rem;
		logic [DIV_Q_W-1:0] low;
		logic [DIV_Q_W-1:0] q;
	} div_lane_t;

	function automatic div_lane_t div_step(input div_lane_t a, input logic [TIME_W-1:0] den);
		logic [TIME_W:0] trial;
		div_lane_t r;
		trial = {a.rem, a.low[DIV_Q_W-1]};
		r.low = {a.low[DIV_Q_W-2:0], 1'b0};
		if (trial >= {1'b0, den}) begin
			r.rem = TIME_W'(trial - {1'b0, den});
			r.q = {a.q[DIV_Q_W-2:0], 1'b1};
		end else begin
			r.rem = trial[TIME_W-1:0];
			r.q = {a.q[DIV_Q_W-2:0], 1'b0};
		end
		return r;
	endfunction

	// cos(pi/2 * x), x in Q30, result Q15
	function automatic longint quarter_cos(input longint x);
		longint u;
		longint p;
		longint c;
		u = (x * x) >>> 30;
		p = 64'sd27061;
		p = 64'sd987048 - ((p * u) >>> 30);
		p = 64'sd22401992 - ((p * u) >>> 30);
		p = 64'sd272375562 - ((p * u) >>> 30);
		p = 64'sd1324675879 - ((p * u) >>> 30);
		c = 64'sd1073741824 - ((p * u) >>> 30);
		if (c < 0)
			c = 0;
		c = (c + 64'sd16384) >>> 15;
		if (c > 64'sd32767)
			c = 64'sd32767;
		return c;
	endfunction

	function automatic logic signed [COS_W-1:0] cos_entry(input int k, input int bits);
		int q;
		longint qmask;
		longint x;
		longint v;
		qmask = (longint'(1) << (bits - 2)) - 1;
		q = (k >> (bits - 2)) & 3;
		x = (longint'(k) & qmask) << (32 - bits);
		case (q)
			0:       v = quarter_cos(x);
			1:       v = -quarter_cos(64'sd1073741824 - x);
			2:       v = -quarter_cos(x);
			default: v = quarter_cos(64'sd1073741824 - x);
		endcase
		return COS_W'(v);
	endfunction

endpackage

// ===== src/rdsd_regs.sv =====
module rdsd_regs
	import rdsd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_DC_LEVEL:  cfg_q.dc_level <= pwdata[AMP_W-1:0];
				REG_AC_AMP:    cfg_q.ac_amplitude <= pwdata[AMP_W-1:0];
				REG_PH_STEP:   cfg_q.phase_step <= pwdata;
				REG_PH_OFFSET: cfg_q.phase_offset <= pwdata[15:0];
				REG_DELAY:     cfg_q.delay_ticks <= pwdata;
				REG_RISE:      cfg_q.rise_ticks <= pwdata;
				REG_ENV_END:   cfg_q.envelope_end_ticks <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_DC_LEVEL:  prdata = DATA_W'(cfg_q.dc_level);
			REG_AC_AMP:    prdata = DATA_W'(cfg_q.ac_amplitude);
			REG_PH_STEP:   prdata = cfg_q.phase_step;
			REG_PH_OFFSET: prdata = {16'b0, cfg_q.phase_offset};
			REG_DELAY:     prdata = cfg_q.delay_ticks;
			REG_RISE:      prdata = cfg_q.rise_ticks;
			REG_ENV_END:   prdata = cfg_q.envelope_end_ticks;
			default:       prdata = '0;
		endcase
	end

endmodule

// ===== src/rdsd_front.sv =====
module rdsd_front
	import rdsd_pkg::*;
#(
	parameter int COS_TABLE_BITS = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 in_valid,
	input  logic [TIME_W-1:0]    sample_time,
	output logic                 out_valid,
	output logic [DIV_NUM_W-1:0] dc_num,
	output logic [DIV_NUM_W-1:0] env_num,
	output side_t                side
);

	localparam int COS_SIZE = 1 << COS_TABLE_BITS;

	logic signed [COS_W-1:0] cos_rom [COS_SIZE];

	for (genvar k = 0; k < COS_SIZE; k++) begin : g_rom
		assign cos_rom[k] = cos_entry(k, COS_TABLE_BITS);
	end

	logic                   valid_s1, valid_s2, valid_s3;
	logic [TIME_W-1:0]      t_s1, diff_s1;
	logic                   ramp_on_s1, ac_on_s1, env_on_s1;
	logic [AMP_W-1:0]       dc_mag_s1, env_mag_s1;
	logic                   dc_neg_s1, env_neg_s1;

	logic [DIV_NUM_W-1:0]   dc_num_s2, env_num_s2;
	logic [31:0]            phase_s2;
	logic                   ramp_on_s2, ac_on_s2, env_on_s2, dc_neg_s2, env_neg_s2;

	logic [DIV_NUM_W-1:0]   dc_num_s3, env_num_s3;
	side_t                  side_s3;

	logic [DIV_NUM_W-1:0]   dc_prod, env_prod;
	logic [31:0]            ph_prod;
	logic [COS_TABLE_BITS-1:0] rom_idx;

	assign dc_prod  = dc_mag_s1 * t_s1;
	assign env_prod = env_mag_s1 * t_s1;
	assign ph_prod  = cfg.phase_step * diff_s1;
	assign rom_idx  = phase_s2[31 -: COS_TABLE_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		t_s1       <= sample_time;
		diff_s1    <= sample_time - cfg.delay_ticks;
		ramp_on_s1 <= (cfg.rise_ticks != '0) && (sample_time < cfg.rise_ticks);
		ac_on_s1   <= sample_time > cfg.delay_ticks;
		env_on_s1  <= (cfg.envelope_end_ticks != '0) && (sample_time < cfg.envelope_end_ticks);
		dc_neg_s1  <= cfg.dc_level[AMP_W-1];
		env_neg_s1 <= cfg.ac_amplitude[AMP_W-1];
		dc_mag_s1  <= cfg.dc_level[AMP_W-1] ? AMP_W'(-cfg.dc_level) : cfg.dc_level;
		env_mag_s1 <= cfg.ac_amplitude[AMP_W-1] ? AMP_W'(-cfg.ac_amplitude)
		                                        : cfg.ac_amplitude;

		dc_num_s2  <= dc_prod;
		env_num_s2 <= env_prod;
		phase_s2   <= ph_prod + {cfg.phase_offset, 16'b0};
		ramp_on_s2 <= ramp_on_s1;
		ac_on_s2   <= ac_on_s1;
		env_on_s2  <= env_on_s1;
		dc_neg_s2  <= dc_neg_s1;
		env_neg_s2 <= env_neg_s1;

		dc_num_s3       <= dc_num_s2;
		env_num_s3      <= env_num_s2;
		side_s3.ramp_on <= ramp_on_s2;
		side_s3.env_on  <= env_on_s2;
		side_s3.dc_neg  <= dc_neg_s2;
		side_s3.env_neg <= env_neg_s2;
		// no cosine term before the delay
		side_s3.cos_val <= ac_on_s2 ? cos_rom[rom_idx] : '0;
	end

	assign out_valid = valid_s3;
	assign dc_num    = dc_num_s3;
	assign env_num   = env_num_s3;
	assign side      = side_s3;

endmodule

// ===== src/rdsd_div.sv =====
module rdsd_div
	import rdsd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [DIV_NUM_W-1:0] dc_num,
	input  logic [DIV_NUM_W-1:0] env_num,
	input  side_t                side_in,
	input  logic [TIME_W-1:0]    dc_den,
	input  logic [TIME_W-1:0]    env_den,
	output logic                 out_valid,
	output logic [DIV_Q_W-1:0]   dc_quot,
	output logic [DIV_Q_W-1:0]   env_quot,
	output side_t                side_out
);

	// restoring division, one quotient bit per stage; numerator < 2^23 * divisor
	div_lane_t          dc_s   [DIV_STAGES+1];
	div_lane_t          env_s  [DIV_STAGES+1];
	side_t              side_s [DIV_STAGES+1];
	logic [DIV_STAGES:0] valid_s;

	assign dc_s[0]   = '{rem: dc_num[DIV_NUM_W-1 -: TIME_W], low: dc_num[DIV_Q_W-1:0], q: '0};
	assign env_s[0]  = '{rem: env_num[DIV_NUM_W-1 -: TIME_W], low: env_num[DIV_Q_W-1:0], q: '0};
	assign side_s[0] = side_in;
	assign valid_s[0] = in_valid;

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else begin
				valid_s[i+1] <= valid_s[i];
			end
		end

		always_ff @(posedge clk) begin
			dc_s[i+1]   <= div_step(dc_s[i], dc_den);
			env_s[i+1]  <= div_step(env_s[i], env_den);
			side_s[i+1] <= side_s[i];
		end
	end

	assign out_valid = valid_s[DIV_STAGES];
	assign dc_quot   = dc_s[DIV_STAGES].q;
	assign env_quot  = env_s[DIV_STAGES].q;
	assign side_out  = side_s[DIV_STAGES];

endmodule

// ===== src/rdsd_back.sv =====
module rdsd_back
	import rdsd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	input  logic [DIV_Q_W-1:0] dc_quot,
	input  logic [DIV_Q_W-1:0] env_quot,
	input  side_t              side,
	output logic               result_valid,
	output logic [OUT_W-1:0]   source_value,
	output logic               saturated
);

	localparam int PROD_W = AMP_W + COS_W;
	localparam int AC_W = PROD_W + 1 - 15;

	logic                     valid_s1, valid_s2, valid_q;
	logic signed [AMP_W-1:0]  dc_s1, amp_s1, dc_s2;
	logic signed [COS_W-1:0]  cos_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic [OUT_W-1:0]         value_q;
	logic                     sat_q;

	logic signed [AMP_W-1:0]  dc_sel, amp_sel;
	logic signed [PROD_W:0]   rnd;
	logic signed [AC_W-1:0]   ac_term;
	logic signed [OUT_W:0]    sum;

	always_comb begin
		if (side.ramp_on)
			dc_sel = side.dc_neg ? -$signed(dc_quot) : $signed(dc_quot);
		else
			dc_sel = cfg.dc_level;
		if (side.env_on)
			amp_sel = side.env_neg ? -$signed(env_quot) : $signed(env_quot);
		else
			amp_sel = cfg.ac_amplitude;
	end

	// round to nearest, ties up, is floor((p + 2^14) / 2^15)
	assign rnd     = $signed({prod_s2[PROD_W-1], prod_s2}) + (PROD_W+1)'(16384);
	assign ac_term = rnd[PROD_W:15];
	assign sum     = (OUT_W+1)'(dc_s2) + (OUT_W+1)'(ac_term);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_q  <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		dc_s1   <= dc_sel;
		amp_s1  <= amp_sel;
		cos_s1  <= side.cos_val;
		dc_s2   <= dc_s1;
		prod_s2 <= amp_s1 * cos_s1;
		if (sum[OUT_W] != sum[OUT_W-1]) begin
			value_q <= sum[OUT_W] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
			sat_q   <= 1'b1;
		end else begin
			value_q <= sum[OUT_W-1:0];
			sat_q   <= 1'b0;
		end
	end

	assign result_valid = valid_q;
	assign source_value = value_q;
	assign saturated    = sat_q;

endmodule

// ===== src/ramped_dc_sine_source.sv =====
// Pipeline: 3 front stages, 24 divider stages and 3 output stages (incl. the output
// register) lie between the start edge and the result strobe.
// Throughput: one item per clock; busy is never asserted.
// The receiver cannot stall; each result is shown for one cycle only.
// Reset (arst_n low, asynchronous): config registers to zero, pipeline emptied.
module ramped_dc_sine_source
	import rdsd_pkg::*;
#(
	parameter int COS_TABLE_BITS = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [TIME_W-1:0] sample_time,
	output logic              result_valid,
	output logic [OUT_W-1:0]  source_value,
	output logic              saturated,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t                 cfg;
	logic                 fr_valid, dv_valid;
	logic [DIV_NUM_W-1:0] dc_num, env_num;
	side_t                fr_side, dv_side;
	logic [DIV_Q_W-1:0]   dc_quot, env_quot;

	assign busy = 1'b0;

	rdsd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rdsd_front #(
		.COS_TABLE_BITS (COS_TABLE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (start && !busy),
		.sample_time (sample_time),
		.out_valid   (fr_valid),
		.dc_num      (dc_num),
		.env_num     (env_num),
		.side        (fr_side)
	);

	rdsd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.dc_num    (dc_num),
		.env_num   (env_num),
		.side_in   (fr_side),
		.dc_den    (cfg.rise_ticks),
		.env_den   (cfg.envelope_end_ticks),
		.out_valid (dv_valid),
		.dc_quot   (dc_quot),
		.env_quot  (env_quot),
		.side_out  (dv_side)
	);

	rdsd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (dv_valid),
		.dc_quot      (dc_quot),
		.env_quot     (env_quot),
		.side         (dv_side),
		.result_valid (result_valid),
		.source_value (source_value),
		.saturated    (saturated)
	);

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import rdsd_pkg::*;

	localparam int COS_BITS = 10;
	localparam int COS_SIZE = 1 << COS_BITS;
	localparam int PIPE_LATENCY = 30;
	localparam int END_WAIT = 2 * PIPE_LATENCY + 10;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int N_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 150;

	typedef struct {
		logic [OUT_W-1:0] value;
		logic             sat;
	} sample_t;

	typedef enum {ROW_WRITE, ROW_SAMPLE} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		reg_idx_t    idx;
		logic [31:0] data;
		logic        fixed;
		logic [31:0] value;
	} row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [TIME_W-1:0] sample_time;
	logic              result_valid;
	logic [OUT_W-1:0]  source_value;
	logic              saturated;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// typed expectation travels with the item
	logic              pin_fixed;
	logic [OUT_W-1:0]  pin_value;

	// register shadow
	logic signed [AMP_W-1:0] dc_lvl;
	logic signed [AMP_W-1:0] ac_amp;
	logic [31:0]             ph_step;
	logic [15:0]             ph_offset;
	logic [TIME_W-1:0]       delay_len;
	logic [TIME_W-1:0]       rise_len;
	logic [TIME_W-1:0]       env_len;

	logic signed [15:0] cos_lut [COS_SIZE];
	sample_t            pending_samples[$];
	int                 n_fail = 0;

	logic [31:0] cur_rise;
	logic [31:0] cur_delay;
	logic [31:0] cur_env;

	ramped_dc_sine_source #(.COS_TABLE_BITS(COS_BITS)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.sample_time(sample_time),
		.result_valid(result_valid),
		.source_value(source_value),
		.saturated(saturated),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// quarter-wave cosine, x in Q30 over [0, 1], Q15 result
	function automatic longint cos_quarter_q15(input longint x);
		longint coef [5];
		longint u;
		longint p;
		longint c;
		coef = '{27061, 987048, 22401992, 272375562, 1324675879};
		u = (x * x) >>> 30;
		p = coef[0];
		for (int i = 1; i < 5; i++)
			p = coef[i] - ((p * u) >>> 30);
		c = 64'sd1073741824 - ((p * u) >>> 30);
		if (c < 0)
			c = 0;
		c = (c + 16384) >>> 15;
		return (c > 32767) ? 64'sd32767 : c;
	endfunction

	function automatic sample_t source_sample(input logic [TIME_W-1:0] t);
		longint      acc;
		longint      amp;
		longint      tl;
		logic [31:0] ph;
		sample_t     r;
		tl = longint'({32'd0, t});
		acc = longint'(dc_lvl);
		if (rise_len != 0 && t < rise_len)
			acc = (acc * tl) / longint'({32'd0, rise_len});
		if (t > delay_len) begin
			ph = ph_step * (t - delay_len) + {ph_offset, 16'h0000};
			amp = longint'(ac_amp);
			if (env_len != 0 && t < env_len)
				amp = (amp * tl) / longint'({32'd0, env_len});
			acc += (amp * longint'(cos_lut[ph >> (32 - COS_BITS)]) + 16384) >>> 15;
		end
		r.sat = 1'b0;
		if (acc > 64'sd2147483647) begin
			acc = 64'sd2147483647;
			r.sat = 1'b1;
		end
		if (acc < -64'sd2147483648) begin
			acc = -64'sd2147483648;
			r.sat = 1'b1;
		end
		r.value = acc[OUT_W-1:0];
		return r;
	endfunction

	always @(posedge clk) begin
		sample_t exp_s;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[ADDR_W-1:2]))
					REG_DC_LEVEL:  dc_lvl = pwdata[AMP_W-1:0];
					REG_AC_AMP:    ac_amp = pwdata[AMP_W-1:0];
					REG_PH_STEP:   ph_step = pwdata;
					REG_PH_OFFSET: ph_offset = pwdata[15:0];
					REG_DELAY:     delay_len = pwdata;
					REG_RISE:      rise_len = pwdata;
					REG_ENV_END:   env_len = pwdata;
					default: ;
				endcase
			end
			if (start && !busy) begin
				if (pin_fixed) begin
					exp_s.value = pin_value;
					exp_s.sat = 1'b0;
				end else begin
					exp_s = source_sample(sample_time);
				end
				pending_samples.push_back(exp_s);
			end
			if (result_valid) begin
				if (pending_samples.size() == 0) begin
					n_fail++;
					if (n_fail <= 10)
						$display("unexpected result: source_value %h saturated %b",
							source_value, saturated);
				end else begin
					exp_s = pending_samples.pop_front();
					if (source_value !== exp_s.value || saturated !== exp_s.sat) begin
						n_fail++;
						if (n_fail <= 10)
							$display("mismatch: source_value exp %h got %h, saturated exp %b got %b",
								exp_s.value, source_value, exp_s.sat, saturated);
					end
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || result_valid || (psel && penable && pwrite && pready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Verification failed");
		$finish;
	end

	// all tasks are entered and left right after a falling edge
	task automatic send_item(input logic [31:0] t, input logic fixed, input logic [31:0] value);
		start <= 1'b1;
		sample_time <= t;
		pin_fixed <= fixed;
		pin_value <= value;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (pending_samples.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_span();
		case ($urandom_range(0, 5))
			0:       return 32'h0;
			1:       return 32'hFFFF_FFFF;
			2:       return $urandom;
			default: return $urandom_range(1, 4096);
		endcase
	endfunction

	function automatic logic [31:0] pick_amp();
		case ($urandom_range(0, 3))
			0:       return 32'h007F_FFFF;
			1:       return 32'hFF80_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_time();
		case ($urandom_range(0, 9))
			0, 1:       return $urandom;
			2, 3, 4, 5: return $urandom_range(0, 8191);
			6:          return cur_rise + $urandom_range(0, 4) - 2;
			7:          return cur_delay + $urandom_range(0, 4) - 2;
			8:          return cur_env + $urandom_range(0, 4) - 2;
			default:    return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
		endcase
	endfunction

	task automatic configure_phase(input int phase);
		logic [31:0] dc;
		logic [31:0] ac;
		case (phase)
			0: begin
				dc = 32'h007F_FFFF;
				ac = 32'h007F_FFFF;
				cur_delay = 0;
				cur_rise = 0;
				cur_env = 0;
			end
			1: begin
				dc = 32'h0080_0000;
				ac = 32'h0080_0000;
				cur_delay = 0;
				cur_rise = 0;
				cur_env = 0;
			end
			2: begin
				dc = pick_amp();
				ac = pick_amp();
				cur_delay = 32'hFFFF_FFFF;
				cur_rise = 32'hFFFF_FFFF;
				cur_env = 32'hFFFF_FFFF;
			end
			default: begin
				dc = pick_amp();
				ac = pick_amp();
				cur_delay = $urandom_range(0, 1) ? $urandom_range(0, 2048) : pick_span();
				cur_rise = pick_span();
				cur_env = pick_span();
			end
		endcase
		write_reg(REG_DC_LEVEL, dc);
		write_reg(REG_AC_AMP, ac);
		write_reg(REG_PH_STEP, $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom);
		write_reg(REG_PH_OFFSET, $urandom);
		write_reg(REG_DELAY, cur_delay);
		write_reg(REG_RISE, cur_rise);
		write_reg(REG_ENV_END, cur_env);
		if ($urandom_range(0, 1))
			write_reg(REG_NONE, $urandom);
	endtask

	initial begin
		row_t directed [30];
		int   idle_pct [4];
		int   idle;
		arst_n = 1'b0;
		start = 1'b0;
		sample_time = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pin_fixed = 1'b0;
		pin_value = '0;
		dc_lvl = '0;
		ac_amp = '0;
		ph_step = '0;
		ph_offset = '0;
		delay_len = '0;
		rise_len = '0;
		env_len = '0;
		idle_pct = '{0, 64, 0, 38};

		for (int k = 0; k < COS_SIZE; k++) begin
			longint pos;
			pos = longint'(k & (COS_SIZE / 4 - 1)) << (32 - COS_BITS);
			case (k >> (COS_BITS - 2))
				0:       cos_lut[k] = 16'(cos_quarter_q15(pos));
				1:       cos_lut[k] = 16'(-cos_quarter_q15(64'sd1073741824 - pos));
				2:       cos_lut[k] = 16'(-cos_quarter_q15(pos));
				default: cos_lut[k] = 16'(cos_quarter_q15(64'sd1073741824 - pos));
			endcase
		end

		directed = '{
			'{ROW_SAMPLE, REG_NONE,      32'h0000_0000, 1'b1, 32'h0000_0000},
			'{ROW_SAMPLE, REG_NONE,      32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
			'{ROW_WRITE,  REG_DC_LEVEL,  32'h007F_FFFF, 1'b0, 32'h0},
			'{ROW_SAMPLE, REG_NONE,      32'd12345,     1'b1, 32'h007F_FFFF},
			'{ROW_WRITE,  REG_DC_LEVEL,  32'hFF80_0000, 1'b0, 32'h0},
			'{ROW_SAMPLE, REG_NONE,      32'hFFFF_FFFF, 1'b1, 32'hFF80_0000},
			'{ROW_WRITE,  REG_RISE,      32'd1000,      1'b0, 32'h0},
			'{ROW_SAMPLE, REG_NONE,      32'd0,         1'b1, 32'h0000_0000},
			'{ROW_SAMPLE, REG_NONE,      32'd250,       1'b1, 32'hFFE0_0000},
			'{ROW_SAMPLE, REG_NONE,      32'd999,       1'b0, 32'h0},
			'{ROW_SAMPLE, REG_NONE,      32'd1000,      1'b1, 32'hFF80_0000},
			'{ROW_WRITE,  REG_AC_AMP,    32'h007F_FFFF, 1'b0, 32'h0},
			'{ROW_WRITE,  REG_PH_STEP,   32'h0040_0000, 1'b0, 32'h0},
			'{ROW_WRITE,  REG_DELAY,     32'd500,       1'b0, 32'h0},
			'{ROW_SAMPLE, REG_NONE,      32'd500,       1'b1, 32'hFFC0_0000},
			'{ROW_SAMPLE, REG_NONE,      32'd501,       1'b0, 32'h0},
			'{ROW_WRITE,  REG_ENV_END,   32'd2000,      1'b0, 32'h0},
			'{ROW_SAMPLE, REG_NONE,      32'd600,       1'b0, 32'h0},
			'{ROW_SAMPLE, REG_NONE,      32'd2000,      1'b0, 32'h0},
			'{ROW_WRITE,  REG_PH_OFFSET, 32'h0000_FFFF, 1'b0, 32'h0},
			'{ROW_SAMPLE, REG_NONE,      32'hFFFF_FFFF, 1'b0, 32'h0},
			'{ROW_WRITE,  REG_AC_AMP,    32'h0080_0000, 1'b0, 32'h0},
			'{ROW_WRITE,  REG_PH_STEP,   32'hFFFF_FFFF, 1'b0, 32'h0},
			'{ROW_SAMPLE, REG_NONE,      32'h8000_0000, 1'b0, 32'h0},
			'{ROW_WRITE,  REG_NONE,      32'hFFFF_FFFF, 1'b0, 32'h0},
			'{ROW_SAMPLE, REG_NONE,      32'd1234,      1'b0, 32'h0},
			'{ROW_WRITE,  REG_DELAY,     32'hFFFF_FFFF, 1'b0, 32'h0},
			'{ROW_SAMPLE, REG_NONE,      32'hFFFF_FFFF, 1'b1, 32'hFF80_0000},
			'{ROW_WRITE,  REG_ENV_END,   32'hFFFF_FFFF, 1'b0, 32'h0},
			'{ROW_SAMPLE, REG_NONE,      32'hFFFF_FFFE, 1'b0, 32'h0}
		};

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_WRITE) begin
				drain();
				write_reg(directed[i].idx, directed[i].data);
			end else begin
				send_item(directed[i].data, directed[i].fixed, directed[i].value);
			end
		end

		for (int phase = 0; phase < N_PHASES; phase++) begin
			drain();
			configure_phase(phase);
			idle = idle_pct[phase % 4];
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (i == ITEMS_PER_PHASE / 2 && phase % 2 == 0)
					drain();
				while ($urandom_range(0, 99) < idle) begin
					start <= 1'b0;
					@(negedge clk);
				end
				send_item(pick_time(), 1'b0, 32'h0);
			end
		end

		drain();
		repeat (END_WAIT) @(negedge clk);
		if (n_fail == 0 && pending_samples.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
